// ===== src/assert_macros.svh =====
// Assertion helpers shared by the deframer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while in reset.
`define SPDC_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication, off while in reset.
`define SPDC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

// ===== src/spdc_pkg.sv =====
`default_nettype none

package spdc_pkg;

    localparam logic [7:0]  SYNC_BYTE     = 8'h55;
    localparam logic [16:0] MAX_PKT_RESET = 17'd64;

    typedef logic [2:0] kind_t;

    localparam kind_t KIND_PAYLOAD  = 3'd0;
    localparam kind_t KIND_GOOD     = 3'd1;
    localparam kind_t KIND_HDR_CRC  = 3'd2;
    localparam kind_t KIND_TOO_LONG = 3'd3;
    localparam kind_t KIND_DATA_CRC = 3'd4;

    typedef struct packed {
        logic        emit;
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic [7:0]  packet_type;
        logic [15:0] data_length;
        logic [7:0]  optional_length;
    } result_t;

    // CRC-8, polynomial 0x07, one byte
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ 8'h07;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/spdc_if.sv =====
`default_nettype none

interface spdc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface spdc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  payload_byte;
    logic [7:0]  packet_type;
    logic [15:0] data_length;
    logic [7:0]  optional_length;

    modport source (output valid, output kind, output payload_byte, output packet_type,
                    output data_length, output optional_length, input ready);
    modport sink (input valid, input kind, input payload_byte, input packet_type,
                  input data_length, input optional_length, output ready);
endinterface

interface spdc_cfg_if;
    logic        valid;
    logic        ready;
    logic [16:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/spdc_in_stage.sv =====
`default_nettype none
`include "assert_macros.svh"

module spdc_in_stage
    import spdc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    spdc_in_if.sink    rx,
    input  wire logic  slot_free,
    output logic       advance,
    output logic [7:0] byte_data
);

    logic       in_valid_reg;
    logic [7:0] byte_reg;

    assign advance   = in_valid_reg && slot_free;
    assign rx.ready  = !in_valid_reg || advance;
    assign byte_data = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            byte_reg <= rx.rx_byte;
        end
    end

    `SPDC_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, in_valid_reg && !slot_free, in_valid_reg)

endmodule

`default_nettype wire

// ===== src/spdc_frame_fsm.sv =====
`default_nettype none
`include "assert_macros.svh"

module spdc_frame_fsm
    import spdc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        advance,
    input  wire logic [7:0]  byte_data,
    input  wire logic        cfg_valid,
    input  wire logic [16:0] cfg_data,
    output result_t          result
);

    localparam logic [1:0] PH_HUNT   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  hs_reg, hs_next;
    logic [7:0]  hdr_reg [4];
    logic [7:0]  hdr_next [4];
    logic [16:0] rem_reg, rem_next;
    logic [7:0]  crc_reg, crc_next;
    logic [16:0] max_reg;

    logic [7:0]  crc_step;
    logic [2:0]  hs_inc;
    logic [16:0] total;

    assign crc_step = crc8_step(crc_reg, byte_data);
    assign hs_inc   = hs_reg + 3'd1;
    assign total    = {1'b0, hdr_reg[0], hdr_reg[1]} + {9'd0, hdr_reg[2]} + 17'd1;

    always_comb
    begin
        phase_next = phase_reg;
        hs_next    = hs_reg;
        hdr_next   = hdr_reg;
        rem_next   = rem_reg;
        crc_next   = crc_reg;

        result.emit            = 1'b0;
        result.kind            = KIND_PAYLOAD;
        result.payload_byte    = 8'd0;
        result.packet_type     = hdr_reg[3];
        result.data_length     = {hdr_reg[0], hdr_reg[1]};
        result.optional_length = hdr_reg[2];

        unique case (phase_reg)
            PH_HEADER:
            begin
                if (hs_reg < 3'd4)
                begin
                    hdr_next[hs_reg[1:0]] = byte_data;
                end
                crc_next = crc_step;
                hs_next  = hs_inc;
                if (hs_inc >= 3'd5)
                begin
                    hs_next = 3'd0;
                    if (crc_step != 8'd0)
                    begin
                        phase_next  = PH_HUNT;
                        result.emit = 1'b1;
                        result.kind = KIND_HDR_CRC;
                    end
                    else if (total > max_reg)
                    begin
                        phase_next  = PH_HUNT;
                        result.emit = 1'b1;
                        result.kind = KIND_TOO_LONG;
                    end
                    else
                    begin
                        rem_next   = total;
                        crc_next   = 8'd0;
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                crc_next    = crc_step;
                result.emit = 1'b1;
                if (rem_reg > 17'd1)
                begin
                    rem_next            = rem_reg - 17'd1;
                    result.kind         = KIND_PAYLOAD;
                    result.payload_byte = byte_data;
                end
                else
                begin
                    rem_next    = 17'd0;
                    phase_next  = PH_HUNT;
                    result.kind = (crc_step == 8'd0) ? KIND_GOOD : KIND_DATA_CRC;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
                if (byte_data == SYNC_BYTE)
                begin
                    phase_next = PH_HEADER;
                    hs_next    = 3'd0;
                    crc_next   = 8'd0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            hs_reg    <= 3'd0;
            hdr_reg   <= '{default: 8'd0};
            rem_reg   <= 17'd0;
            crc_reg   <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            hs_reg    <= hs_next;
            hdr_reg   <= hdr_next;
            rem_reg   <= rem_next;
            crc_reg   <= crc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= MAX_PKT_RESET;
        end
        else if (cfg_valid)
        begin
            max_reg <= cfg_data;
        end
    end

    `SPDC_ASSERT_IMPL(a_hdr_count_range, clk, rst_n, 1'b1, hs_reg <= 3'd4)
    `SPDC_ASSERT_IMPL(a_data_count_live, clk, rst_n, phase_reg == PH_DATA, rem_reg != 17'd0)
    `SPDC_ASSERT_NEXT(a_verdict_ends_packet, clk, rst_n, advance && result.emit && result.kind != KIND_PAYLOAD, phase_reg == PH_HUNT)

endmodule

`default_nettype wire

// ===== src/spdc_out_stage.sv =====
`default_nettype none
`include "assert_macros.svh"

module spdc_out_stage
    import spdc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    advance,
    input  wire result_t result,
    output logic         slot_free,
    spdc_out_if.source   res
);

    logic    valid_reg;
    result_t data_reg;

    assign slot_free           = !valid_reg || res.ready;
    assign res.valid           = valid_reg;
    assign res.kind            = data_reg.kind;
    assign res.payload_byte    = data_reg.payload_byte;
    assign res.packet_type     = data_reg.packet_type;
    assign res.data_length     = data_reg.data_length;
    assign res.optional_length = data_reg.optional_length;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            valid_reg <= advance && result.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.emit)
        begin
            data_reg <= result;
        end
    end

    `SPDC_ASSERT_NEXT(a_result_loaded, clk, rst_n, advance && result.emit, valid_reg && data_reg.kind == $past(result.kind))

endmodule

`default_nettype wire

// ===== src/serial_packet_deframer_crc8_unit.sv =====
// Channel   Dir   Payload                                          Handshake
// rx        in    rx_byte[7:0]                                     valid/ready
// res       out   kind[2:0] payload_byte packet_type data_length   valid/ready
//                 optional_length
// cfg       in    data[16:0] -> max_packet_bytes                   valid/ready (ready = 1)
//
// One item per cycle while res does not stall: input register, one pass of frame logic, output register.
// res valid rises once an accepted byte has passed the input and output registers; items without a result vanish.
// The input register absorbs one item while a result waits on res.
// rst_n clears the frame state to hunting and max_packet_bytes to 64.
`default_nettype none

module serial_packet_deframer_crc8_unit
    import spdc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    spdc_in_if.sink   rx,
    spdc_out_if.source res,
    spdc_cfg_if.sink  cfg
);

    logic       slot_free;
    logic       advance;
    logic [7:0] byte_data;
    result_t    result;

    assign cfg.ready = 1'b1;

    spdc_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .slot_free (slot_free),
        .advance   (advance),
        .byte_data (byte_data)
    );

    spdc_frame_fsm u_frame_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .byte_data (byte_data),
        .cfg_valid (cfg.valid),
        .cfg_data  (cfg.data),
        .result    (result)
    );

    spdc_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .result    (result),
        .slot_free (slot_free),
        .res       (res)
    );

endmodule

`default_nettype wire
